@@ src/kcwt_pkg.sv @@
// shared types, codes and constants of the keyed cost window tracker
`timescale 1ns / 1ps
package kcwt_pkg;

    // default sizes
    localparam int unsigned ENTRIES_DEF = 64;
    localparam int unsigned WINDOW_DEF  = 16;

    // fixed field widths
    localparam int unsigned ACT_W      = 3;
    localparam int unsigned KEY_W      = 64;
    localparam int unsigned COST_W     = 32;
    localparam int unsigned FRAME_W    = 32;
    localparam int unsigned EXP_W      = 16;
    localparam int unsigned PER_W      = 10;
    localparam int unsigned ERASE_W    = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // register reset values
    localparam logic [EXP_W-1:0]   EXPIRY_RST = 16'd600;
    localparam logic [PER_W-1:0]   PERIOD_RST = 10'd30;
    localparam logic [ERASE_W-1:0] ERASE_RST  = 7'd4;

    // largest cost value
    localparam logic [COST_W-1:0] COST_MAX = 32'hFFFF_FFFF;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_BEGIN  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_END    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_COMMIT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_CL_RD,
        ST_CL_CHK,
        ST_LK_RD,
        ST_LK_CHK,
        ST_ACT,
        ST_CM_CALC,
        ST_CM_DIV,
        ST_CM_WAIT,
        ST_FL_RD,
        ST_FL_CHK,
        ST_FL_DIV,
        ST_FL_WAIT,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        DIV_MOD,
        DIV_AVG,
        DIV_FLEET
    } div_mode_t;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      tick;
        logic      walk_clr;
        logic      walk_inc;
        logic      cl_eval;
        logic      lk_eval;
        logic      begin_op;
        logic      write_prog;
        logic      commit_calc;
        logic      commit_wr;
        logic      res_entry;
        logic      fl_eval;
        logic      res_div;
        logic      div_start;
        div_mode_t div_mode;
        logic      emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             step;
        logic             period_zero;
        logic             div_done;
        logic             rem_zero;
        logic             walk_last;
        logic             match;
        logic             found;
        logic             fill_nz;
        logic             count_zero;
        logic             out_free;
    } stat_t;

endpackage

@@ src/kcwt_req_if.sv @@
// input item channel
`timescale 1ns / 1ps
interface kcwt_req_if;
    logic                          valid;
    logic                          ready;
    logic [kcwt_pkg::ACT_W-1:0]    action;
    logic [kcwt_pkg::KEY_W-1:0]    item_key;
    logic                          step_number;
    logic [kcwt_pkg::COST_W-1:0]   measured_us;

    modport source (output valid, action, item_key, step_number, measured_us, input ready);
    modport sink (input valid, action, item_key, step_number, measured_us, output ready);
endinterface

@@ src/kcwt_rsp_if.sv @@
// result item channel
`timescale 1ns / 1ps
interface kcwt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [kcwt_pkg::COST_W-1:0]   result_us;
    logic                          key_present;
    logic                          table_full;

    modport source (output valid, result_us, key_present, table_full, input ready);
    modport sink (input valid, result_us, key_present, table_full, output ready);
endinterface

@@ src/kcwt_cfg_if.sv @@
// configuration write channel
`timescale 1ns / 1ps
interface kcwt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kcwt_pkg::CFG_IDX_W-1:0]   index;
    logic [kcwt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/kcwt_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module kcwt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/kcwt_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module kcwt_div #(
    parameter int unsigned DVD_W = 42,
    parameter int unsigned DVS_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);
    localparam int unsigned CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             q_bit;

    // trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, q_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        q_bit = (trial >= {1'b0, dvs_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DVD_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;
endmodule

@@ src/kcwt_ctrl.sv @@
// sequencing state machine of the tracker
`timescale 1ns / 1ps
module kcwt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kcwt_pkg::stat_t stat,
    output kcwt_pkg::cmd_t  cmd
);
    import kcwt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.act) inside
                    ACT_TICK:
                    begin
                        state_next = stat.step ? ST_RESP : ST_MOD_START;
                    end
                    ACT_BEGIN, ACT_END, ACT_COMMIT, ACT_QUERY:
                    begin
                        state_next = ST_LK_RD;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_MOD_START:
            begin
                state_next = stat.period_zero ? ST_RESP : ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.rem_zero ? ST_CL_RD : ST_RESP;
                end
            end
            ST_CL_RD:
            begin
                state_next = ST_CL_CHK;
            end
            ST_CL_CHK:
            begin
                state_next = stat.walk_last ? ST_RESP : ST_CL_RD;
            end
            ST_LK_RD:
            begin
                state_next = ST_LK_CHK;
            end
            ST_LK_CHK:
            begin
                state_next = (stat.match || stat.walk_last) ? ST_ACT : ST_LK_RD;
            end
            ST_ACT:
            begin
                unique case (stat.act) inside
                    ACT_END:
                    begin
                        state_next = (stat.found && stat.step) ? ST_CM_CALC : ST_RESP;
                    end
                    ACT_COMMIT:
                    begin
                        state_next = stat.found ? ST_CM_CALC : ST_RESP;
                    end
                    ACT_QUERY:
                    begin
                        state_next = (stat.found && stat.fill_nz) ? ST_RESP : ST_FL_RD;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_CM_CALC:
            begin
                state_next = ST_CM_DIV;
            end
            ST_CM_DIV:
            begin
                state_next = ST_CM_WAIT;
            end
            ST_CM_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FL_RD:
            begin
                state_next = ST_FL_CHK;
            end
            ST_FL_CHK:
            begin
                state_next = stat.walk_last ? ST_FL_DIV : ST_FL_RD;
            end
            ST_FL_DIV:
            begin
                state_next = stat.count_zero ? ST_RESP : ST_FL_WAIT;
            end
            ST_FL_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DISPATCH:
            begin
                unique case (stat.act) inside
                    ACT_TICK:
                    begin
                        cmd.tick = !stat.step;
                    end
                    ACT_BEGIN, ACT_END, ACT_COMMIT, ACT_QUERY:
                    begin
                        cmd.walk_clr = 1'b1;
                    end
                    default:
                    begin
                        cmd.tick = 1'b0;
                    end
                endcase
            end
            ST_MOD_START:
            begin
                cmd.div_start = !stat.period_zero;
                cmd.div_mode  = DIV_MOD;
            end
            ST_MOD_WAIT:
            begin
                cmd.walk_clr = stat.div_done && stat.rem_zero;
            end
            ST_CL_CHK:
            begin
                cmd.cl_eval  = 1'b1;
                cmd.walk_inc = !stat.walk_last;
            end
            ST_LK_CHK:
            begin
                cmd.lk_eval  = 1'b1;
                cmd.walk_inc = !stat.match && !stat.walk_last;
            end
            ST_ACT:
            begin
                unique case (stat.act) inside
                    ACT_BEGIN:
                    begin
                        cmd.begin_op = !stat.found;
                    end
                    ACT_END:
                    begin
                        cmd.write_prog = stat.found && !stat.step;
                    end
                    ACT_QUERY:
                    begin
                        cmd.res_entry = stat.found && stat.fill_nz;
                        cmd.walk_clr  = !(stat.found && stat.fill_nz);
                    end
                    default:
                    begin
                        cmd.begin_op = 1'b0;
                    end
                endcase
            end
            ST_CM_CALC:
            begin
                cmd.commit_calc = 1'b1;
            end
            ST_CM_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_AVG;
            end
            ST_CM_WAIT:
            begin
                cmd.commit_wr = stat.div_done;
            end
            ST_FL_CHK:
            begin
                cmd.fl_eval  = 1'b1;
                cmd.walk_inc = !stat.walk_last;
            end
            ST_FL_DIV:
            begin
                cmd.div_start = !stat.count_zero;
                cmd.div_mode  = DIV_FLEET;
            end
            ST_FL_WAIT:
            begin
                cmd.res_div = stat.div_done;
            end
            ST_RESP:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end
endmodule

@@ src/kcwt_dp.sv @@
// datapath: slot table, sample windows, walk registers, divider and result register
`timescale 1ns / 1ps
module kcwt_dp #(
    parameter int unsigned ENTRIES = kcwt_pkg::ENTRIES_DEF,
    parameter int unsigned WINDOW  = kcwt_pkg::WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kcwt_pkg::cmd_t                    cmd,
    output kcwt_pkg::stat_t                   stat,
    input  logic [kcwt_pkg::ACT_W-1:0]        action,
    input  logic [kcwt_pkg::KEY_W-1:0]        item_key,
    input  logic                              step_number,
    input  logic [kcwt_pkg::COST_W-1:0]       measured_us,
    input  logic                              cfg_we,
    input  logic [kcwt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kcwt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [kcwt_pkg::COST_W-1:0]       result_us,
    output logic                              key_present,
    output logic                              table_full
);
    import kcwt_pkg::*;

    localparam int unsigned SLOT_W  = $clog2(ENTRIES);
    localparam int unsigned WI_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned FILL_W  = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W   = COST_W + FILL_W;
    localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
    localparam int unsigned TOT_W   = COST_W + CNT_W;
    localparam int unsigned FREED_W = (CNT_W > ERASE_W) ? CNT_W : ERASE_W;
    localparam int unsigned WADDR_W = $clog2(ENTRIES * WINDOW);
    localparam int unsigned DVD_W   = (TOT_W > SUM_W) ? TOT_W : SUM_W;
    localparam int unsigned DVS_A   = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    localparam int unsigned DVS_W   = (DVS_A > PER_W) ? DVS_A : PER_W;

    // slot word layout, low to high
    localparam int unsigned OFS_LCF  = 1;
    localparam int unsigned OFS_FILL = OFS_LCF + FRAME_W;
    localparam int unsigned OFS_WI   = OFS_FILL + FILL_W;
    localparam int unsigned OFS_SUM  = OFS_WI + WI_W;
    localparam int unsigned OFS_PROG = OFS_SUM + SUM_W;
    localparam int unsigned OFS_AVG  = OFS_PROG + COST_W;
    localparam int unsigned OFS_KEY  = OFS_AVG + COST_W;
    localparam int unsigned WORD_W   = OFS_KEY + KEY_W;

    // configuration
    logic [EXP_W-1:0]   expiry_reg;
    logic [PER_W-1:0]   period_reg;
    logic [ERASE_W-1:0] erase_reg;

    // item registers
    logic [ACT_W-1:0]   act_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               step_reg;
    logic [COST_W-1:0]  meas_reg;

    // control state
    logic [FRAME_W-1:0] fc_reg;
    logic [ENTRIES-1:0] slot_valid_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic [FREED_W-1:0] freed_reg;
    logic               found_reg;
    logic               free_found_reg;
    logic               full_reg;
    logic               out_valid_reg;

    // payload registers
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  free_slot_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [COST_W-1:0]  result_reg;
    logic [COST_W-1:0]  out_result_reg;
    logic               out_present_reg;
    logic               out_full_reg;

    // latched slot word
    logic [COST_W-1:0]  w_avg_reg;
    logic [COST_W-1:0]  w_prog_reg;
    logic [SUM_W-1:0]   w_sum_reg;
    logic [WI_W-1:0]    w_wi_reg;
    logic [FILL_W-1:0]  w_fill_reg;
    logic [FRAME_W-1:0] w_lcf_reg;
    logic               w_ec_reg;

    // memories
    logic               slot_we;
    logic [SLOT_W-1:0]  slot_waddr;
    logic [WORD_W-1:0]  slot_wdata;
    logic [WORD_W-1:0]  slot_rdata;
    logic [WADDR_W-1:0] win_addr;
    logic [COST_W-1:0]  win_rdata;

    // divider
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;
    logic [DVS_W-1:0]   div_r;

    // unpacked read word and walk decisions
    logic [KEY_W-1:0]   rd_key;
    logic [COST_W-1:0]  rd_avg;
    logic [COST_W-1:0]  rd_prog;
    logic [SUM_W-1:0]   rd_sum;
    logic [WI_W-1:0]    rd_wi;
    logic [FILL_W-1:0]  rd_fill;
    logic [FRAME_W-1:0] rd_lcf;
    logic               rd_ec;
    logic               cur_valid;
    logic               match;
    logic               expired;
    logic               erase_now;
    logic [FRAME_W-1:0] age;

    // commit arithmetic
    logic [COST_W:0]    raw_sum;
    logic [COST_W-1:0]  cost;
    logic [COST_W-1:0]  old_sample;
    logic [SUM_W-1:0]   sum_next;
    logic [WI_W-1:0]    wi_next;
    logic [FILL_W-1:0]  fill_next;

    always_comb
    begin
        rd_key    = slot_rdata[OFS_KEY +: KEY_W];
        rd_avg    = slot_rdata[OFS_AVG +: COST_W];
        rd_prog   = slot_rdata[OFS_PROG +: COST_W];
        rd_sum    = slot_rdata[OFS_SUM +: SUM_W];
        rd_wi     = slot_rdata[OFS_WI +: WI_W];
        rd_fill   = slot_rdata[OFS_FILL +: FILL_W];
        rd_lcf    = slot_rdata[OFS_LCF +: FRAME_W];
        rd_ec     = slot_rdata[0];
        cur_valid = slot_valid_reg[idx_reg];
        match     = cur_valid && (rd_key == key_reg);
        age       = fc_reg - rd_lcf;
        expired   = !rd_ec || (age >= FRAME_W'(expiry_reg));
        erase_now = cur_valid && expired && (freed_reg < FREED_W'(erase_reg));
    end

    // new sample, running sum and ring position
    always_comb
    begin
        raw_sum    = {1'b0, meas_reg} + {1'b0, w_prog_reg};
        if (act_reg == ACT_END)
        begin
            cost = raw_sum[COST_W] ? COST_MAX : raw_sum[COST_W-1:0];
        end
        else
        begin
            cost = meas_reg;
        end
        old_sample = (w_fill_reg == FILL_W'(WINDOW)) ? win_rdata : '0;
        sum_next   = w_sum_reg - SUM_W'(old_sample) + SUM_W'(cost);
        wi_next    = (w_wi_reg == WI_W'(WINDOW - 1)) ? '0 : w_wi_reg + 1'b1;
        fill_next  = (w_fill_reg == FILL_W'(WINDOW)) ? w_fill_reg : w_fill_reg + 1'b1;
    end

    // slot table write
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = slot_reg;
        slot_wdata = {key_reg, w_avg_reg, w_prog_reg, w_sum_reg, w_wi_reg, w_fill_reg,
                      w_lcf_reg, w_ec_reg};
        if (cmd.begin_op)
        begin
            slot_we    = free_found_reg;
            slot_waddr = free_slot_reg;
            slot_wdata = {key_reg, {(WORD_W - KEY_W){1'b0}}};
        end
        else if (cmd.write_prog)
        begin
            slot_we    = 1'b1;
            slot_wdata = {key_reg, w_avg_reg, meas_reg, w_sum_reg, w_wi_reg, w_fill_reg,
                          w_lcf_reg, w_ec_reg};
        end
        else if (cmd.commit_wr)
        begin
            slot_we    = 1'b1;
            slot_wdata = {key_reg, div_q[COST_W-1:0], w_prog_reg, w_sum_reg, w_wi_reg,
                          w_fill_reg, w_lcf_reg, w_ec_reg};
        end
    end

    kcwt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (idx_reg),
        .rdata (slot_rdata)
    );

    // sample window of the latched slot
    assign win_addr = WADDR_W'(slot_reg) * WADDR_W'(WINDOW) + WADDR_W'(w_wi_reg);

    kcwt_ram #(
        .WIDTH (COST_W),
        .DEPTH (ENTRIES * WINDOW)
    ) u_win_ram (
        .clk   (clk),
        .we    (cmd.commit_calc),
        .waddr (win_addr),
        .wdata (cost),
        .raddr (win_addr),
        .rdata (win_rdata)
    );

    // divider operand select
    always_comb
    begin
        case (cmd.div_mode)
            DIV_MOD:
            begin
                div_dvd = DVD_W'(fc_reg);
                div_dvs = DVS_W'(period_reg);
            end
            DIV_AVG:
            begin
                div_dvd = DVD_W'(w_sum_reg);
                div_dvs = DVS_W'(w_fill_reg);
            end
            DIV_FLEET:
            begin
                div_dvd = DVD_W'(total_reg);
                div_dvs = DVS_W'(count_reg);
            end
            default:
            begin
                div_dvd = '0;
                div_dvs = '0;
            end
        endcase
    end

    kcwt_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg <= EXPIRY_RST;
            period_reg <= PERIOD_RST;
            erase_reg  <= ERASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXPIRY: expiry_reg <= cfg_data[EXP_W-1:0];
                CFG_PERIOD: period_reg <= cfg_data[PER_W-1:0];
                CFG_ERASE:  erase_reg  <= cfg_data[ERASE_W-1:0];
                default:    expiry_reg <= expiry_reg;
            endcase
        end
    end

    // control state: frame count, valid bits, walk, flags, output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg         <= '0;
            slot_valid_reg <= '0;
            idx_reg        <= '0;
            freed_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            full_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.tick)
            begin
                fc_reg <= fc_reg + 1'b1;
            end
            if (cmd.load)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                full_reg       <= 1'b0;
            end
            if (cmd.walk_clr)
            begin
                idx_reg   <= '0;
                freed_reg <= '0;
            end
            else if (cmd.walk_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.cl_eval && erase_now)
            begin
                slot_valid_reg[idx_reg] <= 1'b0;
                freed_reg               <= freed_reg + 1'b1;
            end
            if (cmd.lk_eval)
            begin
                if (match)
                begin
                    found_reg <= 1'b1;
                end
                else if (!cur_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.begin_op)
            begin
                if (free_found_reg)
                begin
                    slot_valid_reg[free_slot_reg] <= 1'b1;
                end
                else
                begin
                    full_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= action;
            key_reg    <= item_key;
            step_reg   <= step_number;
            meas_reg   <= measured_us;
            result_reg <= '0;
        end
        if (cmd.walk_clr)
        begin
            total_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.fl_eval && cur_valid && (rd_fill != '0))
        begin
            total_reg <= total_reg + TOT_W'(rd_avg);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.lk_eval)
        begin
            if (match)
            begin
                slot_reg   <= idx_reg;
                w_avg_reg  <= rd_avg;
                w_prog_reg <= rd_prog;
                w_sum_reg  <= rd_sum;
                w_wi_reg   <= rd_wi;
                w_fill_reg <= rd_fill;
                w_lcf_reg  <= rd_lcf;
                w_ec_reg   <= rd_ec;
            end
            else if (!cur_valid && !free_found_reg)
            begin
                free_slot_reg <= idx_reg;
            end
        end
        if (cmd.commit_calc)
        begin
            w_sum_reg  <= sum_next;
            w_wi_reg   <= wi_next;
            w_fill_reg <= fill_next;
            w_lcf_reg  <= fc_reg;
            w_ec_reg   <= 1'b1;
            if (act_reg == ACT_END)
            begin
                w_prog_reg <= '0;
            end
        end
        if (cmd.res_entry)
        begin
            result_reg <= w_avg_reg;
        end
        else if (cmd.res_div)
        begin
            result_reg <= div_q[COST_W-1:0];
        end
        if (cmd.emit)
        begin
            out_result_reg  <= result_reg;
            out_present_reg <= found_reg;
            out_full_reg    <= full_reg;
        end
    end

    // status to the controller
    always_comb
    begin
        stat.act         = act_reg;
        stat.step        = step_reg;
        stat.period_zero = (period_reg == '0);
        stat.div_done    = div_done;
        stat.rem_zero    = (div_r == '0);
        stat.walk_last   = (idx_reg == SLOT_W'(ENTRIES - 1));
        stat.match       = match;
        stat.found       = found_reg;
        stat.fill_nz     = (w_fill_reg != '0);
        stat.count_zero  = (count_reg == '0);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign result_us   = out_result_reg;
    assign key_present = out_present_reg;
    assign table_full  = out_full_reg;
endmodule

@@ src/keyed_cost_window_tracker.sv @@
// top level of the keyed cost window tracker
`timescale 1ns / 1ps
// The block handles one item at a time and returns exactly one result item for each.
// Key lookup walks the slot table through its single-read-port ram, with an LK_RD and an
// LK_CHK state for each slot, and stops at a match; begin key, end step 0 and a query
// that hits a committed key then go to the response state. A commit adds the CM_CALC
// and CM_DIV setup states and one pass of the bit-serial divider for the new window
// average. A query for an unknown or uncommitted key adds a second table walk and, if
// any slot holds samples, a divider pass instead. A frame tick with step 0 runs the
// divider, unless the period is zero, to test the cleanup interval, and on a zero
// remainder a cleanup pass walks the whole table. Frame tick step 1 and unused actions
// go from dispatch straight to the response state.
// A finished result waits in an output register; the next item is taken once it moved
// there, so a stalled result item holds off the input. Configuration writes are taken
// at any time and act at once, so they belong in gaps with no item in flight.
module keyed_cost_window_tracker #(
    parameter int unsigned ENTRIES = kcwt_pkg::ENTRIES_DEF,
    parameter int unsigned WINDOW  = kcwt_pkg::WINDOW_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    kcwt_req_if.sink     req,
    kcwt_rsp_if.source   rsp,
    kcwt_cfg_if.sink     cfg
);
    import kcwt_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    kcwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kcwt_dp #(
        .ENTRIES (ENTRIES),
        .WINDOW  (WINDOW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (req.action),
        .item_key    (req.item_key),
        .step_number (req.step_number),
        .measured_us (req.measured_us),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .result_us   (rsp.result_us),
        .key_present (rsp.key_present),
        .table_full  (rsp.table_full)
    );

    // one item in flight: no second accept right after one
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("item accepted while previous item in flight");

    // a result never overwrites one that waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!rsp.valid || rsp.ready))
        else $error("result emitted over a pending result");

    // a full table is only reported for an absent key
    a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.table_full && rsp.key_present))
        else $error("table full reported for a present key");
endmodule
